@@ sv/uart_pkg.sv @@
// ----------------------------------------------------------------------------
// UART transceiver package
// Shared widths, reset values and status records for the tick-driven 8N1
// UART transceiver.
// ----------------------------------------------------------------------------
package uart_pkg;

   // Timer and frame geometry.
   localparam int TIMER_WIDTH    = 16;
   localparam int RX_TIMER_WIDTH = TIMER_WIDTH + 1;
   localparam int DATA_BITS      = 8;
   localparam int FRAME_BITS     = DATA_BITS + 2;
   localparam int COUNT_WIDTH    = $clog2(FRAME_BITS + 1);

   // Fixed field widths of the stream payloads.
   localparam int BYTE_WIDTH     = 8;
   localparam int PERIOD_WIDTH   = 16;
   localparam int REQ_DATA_WIDTH = 16;
   localparam int RSP_DATA_WIDTH = 16;

   // Bit period after reset, in timer ticks.
   localparam logic [PERIOD_WIDTH-1:0] BIT_PERIOD_RESET = 16'd104;

   // Transmitter status after one tick.
   typedef struct packed {
      logic line;
      logic busy;
   } tx_status_type;

   // Receiver status after one tick.
   typedef struct packed {
      logic                 valid;
      logic [BYTE_WIDTH-1:0] data;
   } rx_status_type;

endpackage

@@ sv/uart_tx.sv @@
// ----------------------------------------------------------------------------
// UART transmitter
// Advances the transmit frame by one timer tick per step: one bit period of
// mark, a start bit, the data bits LSB first and a stop bit.
// ----------------------------------------------------------------------------
module uart_tx (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic [uart_pkg::TIMER_WIDTH-1:0]     bit_period,
   input  logic                                 tx_request,
   input  logic [uart_pkg::BYTE_WIDTH-1:0]      tx_byte,
   output uart_pkg::tx_status_type              status
);
   import uart_pkg::*;

   logic [TIMER_WIDTH-1:0] timer_ff, timer_in;
   logic [FRAME_BITS-1:0]  shift_ff, shift_in;
   logic [COUNT_WIDTH-1:0] bits_ff, bits_in;
   logic                   level_ff, level_in;

   // Next state for one tick: shift out a bit on timer expiry, then load a
   // new frame if the transmitter is idle and a byte is requested.
   always_comb begin
      timer_in = timer_ff;
      shift_in = shift_ff;
      bits_in  = bits_ff;
      level_in = level_ff;
      if (bits_ff != '0) begin
         if (timer_ff <= TIMER_WIDTH'(1)) begin
            level_in = shift_ff[0];
            shift_in = shift_ff >> 1;
            bits_in  = bits_ff - 1'b1;
            timer_in = bit_period;
         end else begin
            timer_in = timer_ff - 1'b1;
         end
      end
      if (bits_in == '0 && tx_request) begin
         shift_in = {1'b1, tx_byte[DATA_BITS-1:0], 1'b0};
         bits_in  = COUNT_WIDTH'(FRAME_BITS);
         timer_in = bit_period;
      end
   end

   // Status as seen after this tick.
   assign status.line = level_in;
   assign status.busy = (bits_in != '0);

   // State registers advance once per accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
         shift_ff <= '0;
         bits_ff  <= '0;
         level_ff <= 1'b1;
      end else if (step) begin
         timer_ff <= timer_in;
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
         level_ff <= level_in;
      end
   end

endmodule

@@ sv/uart_rx.sv @@
// ----------------------------------------------------------------------------
// UART receiver
// Hunts for a falling edge, waits one and a half bit periods, then samples
// the data bits LSB first one bit period apart and flags the byte.
// ----------------------------------------------------------------------------
module uart_rx (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 step,
   input  logic [uart_pkg::TIMER_WIDTH-1:0]     bit_period,
   input  logic                                 rx_line,
   output uart_pkg::rx_status_type              status
);
   import uart_pkg::*;

   logic [RX_TIMER_WIDTH-1:0] timer_ff, timer_in;
   logic [DATA_BITS-1:0]      shift_ff, shift_in;
   logic [COUNT_WIDTH-1:0]    bits_ff, bits_in;
   logic                      prev_ff;
   logic                      valid;
   logic [RX_TIMER_WIDTH-1:0] start_delay;

   // One and a half bit periods, from the start edge to mid first data bit.
   assign start_delay = {1'b0, bit_period} + {2'b00, bit_period[TIMER_WIDTH-1:1]};

   // Next state for one tick.
   always_comb begin
      timer_in = timer_ff;
      shift_in = shift_ff;
      bits_in  = bits_ff;
      valid    = 1'b0;
      if (bits_ff == '0) begin
         if (prev_ff && !rx_line) begin
            timer_in = start_delay;
            bits_in  = COUNT_WIDTH'(DATA_BITS);
         end
      end else if (timer_ff <= RX_TIMER_WIDTH'(1)) begin
         shift_in = {rx_line, shift_ff[DATA_BITS-1:1]};
         bits_in  = bits_ff - 1'b1;
         timer_in = {1'b0, bit_period};
         valid    = (bits_in == '0);
      end else begin
         timer_in = timer_ff - 1'b1;
      end
   end

   // The byte is shown only on the tick of the last data sample.
   assign status.valid = valid;
   assign status.data  = valid ? shift_in : '0;

   // State registers advance once per accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_ff <= '0;
         shift_ff <= '0;
         bits_ff  <= '0;
         prev_ff  <= 1'b1;
      end else if (step) begin
         timer_ff <= timer_in;
         shift_ff <= shift_in;
         bits_ff  <= bits_in;
         prev_ff  <= rx_line;
      end
   end

endmodule

@@ sv/timer_uart_8n1_transceiver.sv @@
// ----------------------------------------------------------------------------
// Tick-driven 8N1 UART transceiver
// Full-duplex UART where every request is one timer tick carrying the
// sampled receive line and an optional byte to send.
// ----------------------------------------------------------------------------
// Usage:
// Each request on req_ is one timer tick and yields exactly one response on
// rsp_ with the transmit line level, transmit busy, and a received byte with
// its valid flag. A request is taken into an input register, processed by
// the transmitter and receiver once the response register is free, and
// placed in the response register, from which it can be taken. One request
// is accepted every cycle while responses are taken; the rate is set by the
// state update of the transmit and receive timers, which is made as each
// response is registered.
// If rsp_tready is low, the response register holds its data, the input
// register fills, and req_tready drops until the response is taken; no
// tick is lost or repeated. csr_we writes the bit period, which takes effect
// at the next timer reload. Reset sets the bit period to 104, idles the
// transmitter at mark, puts the receiver in hunt and empties both registers.
// ----------------------------------------------------------------------------
module timer_uart_8n1_transceiver (
   input  logic                                  clock,
   input  logic                                  reset,
   // Request: [0] rx_line, [1] tx_request, [9:2] tx_byte, [15:10] zero.
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [uart_pkg::REQ_DATA_WIDTH-1:0]   req_tdata,
   // Response: [0] tx_line, [1] tx_busy, [2] rx_valid, [10:3] rx_byte,
   // [15:11] zero.
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [uart_pkg::RSP_DATA_WIDTH-1:0]   rsp_tdata,
   // Bit period register.
   input  logic                                  csr_we,
   input  logic [uart_pkg::PERIOD_WIDTH-1:0]     csr_wdata
);
   import uart_pkg::*;

   logic                      in_valid_ff;
   logic                      rx_line_ff;
   logic                      tx_request_ff;
   logic [BYTE_WIDTH-1:0]     tx_byte_ff;
   logic                      out_valid_ff, out_valid_in;
   logic [RSP_DATA_WIDTH-1:0] out_data_ff, out_data_in;
   logic [PERIOD_WIDTH-1:0]   bit_period_ff;
   logic                      advance;
   tx_status_type             tx_status;
   rx_status_type             rx_status;

   // A tick moves on when the response register is empty or being emptied.
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Bit period configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_period_ff <= BIT_PERIOD_RESET;
      end else if (csr_we) begin
         bit_period_ff <= csr_wdata;
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         rx_line_ff    <= req_tdata[0];
         tx_request_ff <= req_tdata[1];
         tx_byte_ff    <= req_tdata[9:2];
      end
   end

   // Transmitter and receiver, stepped once per tick.
   uart_tx u_tx (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .bit_period (TIMER_WIDTH'(bit_period_ff)),
      .tx_request (tx_request_ff),
      .tx_byte    (tx_byte_ff),
      .status     (tx_status)
   );

   uart_rx u_rx (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .bit_period (TIMER_WIDTH'(bit_period_ff)),
      .rx_line    (rx_line_ff),
      .status     (rx_status)
   );

   // Response register.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
      out_data_in = {5'b00000, rx_status.data, rx_status.valid,
                     tx_status.busy, tx_status.line};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

@@ test/tb_top.sv @@
// ----------------------------------------------------------------------------
// Testbench for the tick-driven 8N1 UART transceiver
// Every request is one timer tick. A model of the transmitter and receiver
// predicts the line status that each tick returns, and the responses are
// checked field by field in order. Receive traffic is mostly well-formed
// frames at the configured bit period with random data, tx requests and a
// share of noise and broken frames. Both stream sides idle at random. The
// bit period is changed between phases, down to zero and up to its maximum.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import uart_pkg::*;

   localparam int unsigned CYCLE_LIMIT      = 1000000;
   localparam int unsigned DRAIN_CYCLES     = 8;
   localparam int unsigned SINK_HOLD_CYCLES = 200;
   localparam int unsigned RANDOM_TICKS     = 400;
   localparam int unsigned PHASE_TICKS      = 100;
   localparam int unsigned MIN_PHASES       = 4;

   // One tick as it travels on req_tdata, rx_line in bit 0.
   typedef struct packed {
      logic [BYTE_WIDTH-1:0] tx_byte;
      logic                  tx_request;
      logic                  rx_line;
   } tick_type;

   // Line status as it travels on rsp_tdata, tx_line in bit 0.
   typedef struct packed {
      logic [BYTE_WIDTH-1:0] rx_byte;
      logic                  rx_valid;
      logic                  tx_busy;
      logic                  tx_line;
   } line_status_type;

   typedef enum {TX_RARE, TX_OFTEN, TX_ALWAYS} tx_mode_type;

   // Predicts the line status of every accepted tick and checks responses.
   class uart_line_scoreboard;
      logic [PERIOD_WIDTH-1:0]   bit_period;
      logic [TIMER_WIDTH-1:0]    tx_timer;
      logic [FRAME_BITS-1:0]     tx_shift;
      logic [COUNT_WIDTH-1:0]    tx_bits_left;
      logic                      tx_level;
      logic [RX_TIMER_WIDTH-1:0] rx_timer;
      logic [DATA_BITS-1:0]      rx_shift;
      logic [COUNT_WIDTH-1:0]    rx_bits_left;
      logic                      rx_prev_line;
      line_status_type           expected_status_q[$];
      int                        failures;

      function new();
         bit_period   = BIT_PERIOD_RESET;
         tx_timer     = '0;
         tx_shift     = '0;
         tx_bits_left = '0;
         tx_level     = 1'b1;
         rx_timer     = '0;
         rx_shift     = '0;
         rx_bits_left = '0;
         rx_prev_line = 1'b1;
         failures     = 0;
      endfunction

      function void write_bit_period(logic [PERIOD_WIDTH-1:0] value);
         bit_period = value;
      endfunction

      function int pending();
         return expected_status_q.size();
      endfunction

      // Advance both halves by one tick and queue the status it yields.
      function void note_tick(tick_type tick);
         line_status_type status;
         status = '0;

         // Transmitter: shift out the next bit when the bit timer runs out.
         if (tx_bits_left != 0) begin
            if (tx_timer <= 1) begin
               tx_level     = tx_shift[0];
               tx_shift     = tx_shift >> 1;
               tx_bits_left = tx_bits_left - 1'b1;
               tx_timer     = TIMER_WIDTH'(bit_period);
            end else begin
               tx_timer = tx_timer - 1'b1;
            end
         end
         // An idle transmitter takes the byte on this same tick.
         if (tx_bits_left == 0 && tick.tx_request) begin
            tx_shift     = {1'b1, tick.tx_byte[DATA_BITS-1:0], 1'b0};
            tx_bits_left = COUNT_WIDTH'(FRAME_BITS);
            tx_timer     = TIMER_WIDTH'(bit_period);
         end

         // Receiver: hunt for a falling edge, then sample mid-bit.
         if (rx_bits_left == 0) begin
            if (rx_prev_line && !tick.rx_line) begin
               rx_timer = RX_TIMER_WIDTH'(bit_period) + RX_TIMER_WIDTH'(bit_period >> 1);
               rx_bits_left = COUNT_WIDTH'(DATA_BITS);
            end
         end else if (rx_timer <= 1) begin
            rx_shift     = {tick.rx_line, rx_shift[DATA_BITS-1:1]};
            rx_bits_left = rx_bits_left - 1'b1;
            rx_timer     = RX_TIMER_WIDTH'(TIMER_WIDTH'(bit_period));
            if (rx_bits_left == 0) begin
               status.rx_valid = 1'b1;
               status.rx_byte  = BYTE_WIDTH'(rx_shift);
            end
         end else begin
            rx_timer = rx_timer - 1'b1;
         end
         rx_prev_line = tick.rx_line;

         status.tx_line = tx_level;
         status.tx_busy = (tx_bits_left != 0);
         expected_status_q.push_back(status);
      endfunction

      function void report(string field, logic [15:0] want, logic [15:0] got);
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         failures++;
      endfunction

      // Compare one response with the oldest prediction.
      function void check_status(logic [RSP_DATA_WIDTH-1:0] data);
         line_status_type got;
         line_status_type want;
         got = line_status_type'(data[$bits(line_status_type)-1:0]);
         if (expected_status_q.size() == 0) begin
            $display("%0t: response %h arrived with nothing expected", $time, data);
            failures++;
         end else begin
            want = expected_status_q.pop_front();
            if (got.tx_line !== want.tx_line)
               report("tx_line", 16'(want.tx_line), 16'(got.tx_line));
            if (got.tx_busy !== want.tx_busy)
               report("tx_busy", 16'(want.tx_busy), 16'(got.tx_busy));
            if (got.rx_valid !== want.rx_valid)
               report("rx_valid", 16'(want.rx_valid), 16'(got.rx_valid));
            if (got.rx_byte !== want.rx_byte)
               report("rx_byte", 16'(want.rx_byte), 16'(got.rx_byte));
            if (data[RSP_DATA_WIDTH-1:$bits(line_status_type)] !== '0)
               report("padding", '0, 16'(data[RSP_DATA_WIDTH-1:$bits(line_status_type)]));
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      csr_we = 1'b0;
   logic [PERIOD_WIDTH-1:0]   csr_wdata = '0;

   uart_line_scoreboard sb = new();

   logic [PERIOD_WIDTH-1:0] cur_period = BIT_PERIOD_RESET;
   tx_mode_type             tx_mode = TX_RARE;
   bit                      steady = 1'b0;
   bit                      sink_hold_request = 1'b0;
   int unsigned             ticks_sent = 0;
   int unsigned             cycle_count = 0;

   timer_uart_8n1_transceiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   // Check every response taken from the block.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_status(rsp_tdata);
   end

   // Mostly short gaps, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 65)
         return 0;
      if (roll < 95)
         return $urandom_range(1, 3);
      return $urandom_range(4, 40);
   endfunction

   function automatic logic next_tx_request();
      case (tx_mode)
         TX_RARE:  return ($urandom_range(0, 15) == 0);
         TX_OFTEN: return 1'($urandom_range(0, 1));
         default:  return 1'b1;
      endcase
   endfunction

   // Response side pacing, with one long hold-off when asked for.
   initial begin : sink_pacing
      int unsigned stall;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (sink_hold_request) begin
            sink_hold_request = 1'b0;
            rsp_tready <= 1'b0;
            repeat (SINK_HOLD_CYCLES) @(posedge clock);
         end else begin
            stall = steady ? 0 : pick_gap();
            if (stall == 0) begin
               rsp_tready <= 1'b1;
            end else begin
               rsp_tready <= 1'b0;
               repeat (stall - 1) @(posedge clock);
            end
         end
      end
   end

   // Offer one tick and wait until it is accepted. The valid stays high on
   // return so that the next tick can follow without a gap.
   task automatic drive_tick(input logic line, input logic request,
                             input logic [BYTE_WIDTH-1:0] data);
      int unsigned gap;
      tick_type    tick;
      gap             = steady ? 0 : pick_gap();
      tick.rx_line    = line;
      tick.tx_request = request;
      tick.tx_byte    = data;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_DATA_WIDTH'(tick);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_tick(tick);
      ticks_sent++;
   endtask

   // Stop offering and wait until every predicted response has come back.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_bit_period(input logic [PERIOD_WIDTH-1:0] value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_bit_period(value);
      cur_period = value;
   endtask

   // Hold the receive line at one level for a number of ticks.
   task automatic play_bit(input logic level, input int unsigned count);
      repeat (count) drive_tick(level, next_tx_request(), BYTE_WIDTH'($urandom));
   endtask

   // One receive frame, or noise, or a broken frame.
   task automatic play_frame();
      int unsigned           dur;
      int unsigned           kind;
      int unsigned           n_bits;
      logic [BYTE_WIDTH-1:0] data;
      dur  = (cur_period < 2) ? 1 : cur_period;
      kind = $urandom_range(0, 9);
      data = BYTE_WIDTH'($urandom);
      case ($urandom_range(0, 3))
         0:       tx_mode = TX_RARE;
         1, 2:    tx_mode = TX_OFTEN;
         default: tx_mode = TX_ALWAYS;
      endcase
      if (kind == 0) begin
         // Line noise without any frame structure.
         repeat ($urandom_range(1, 3 * dur))
            drive_tick(1'($urandom_range(0, 1)), next_tx_request(), BYTE_WIDTH'($urandom));
      end else begin
         // Some senders run a tick fast or slow per bit.
         if (dur >= 4 && $urandom_range(0, 3) == 0)
            dur = $urandom_range(0, 1) ? dur + 1 : dur - 1;
         // A truncated frame drops back to mark early; another loses its stop bit.
         n_bits = (kind == 1) ? $urandom_range(0, DATA_BITS - 1) : DATA_BITS;
         play_bit(1'b1, $urandom_range(0, 2 * dur));
         play_bit(1'b0, dur);
         for (int i = 0; i < n_bits; i++)
            play_bit(data[i], dur);
         play_bit((kind == 2) ? 1'b0 : 1'b1, dur);
      end
   endtask

   task automatic run_frames(input int unsigned count);
      int unsigned start;
      start = ticks_sent;
      while (ticks_sent - start < count)
         play_frame();
   endtask

   initial begin : stimulus
      int unsigned random_start;
      int unsigned phase;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: an all-ones byte sent, a request dropped while busy, an
      // all-zero byte received, a request on the tick the stop bit begins,
      // and a one-tick glitch that still starts a reception.
      write_bit_period(2);
      drive_tick(1'b1, 1'b1, 8'hFF);
      drive_tick(1'b1, 1'b1, 8'h00);
      drive_tick(1'b0, 1'b0, 8'hA5);
      drive_tick(1'b0, 1'b0, 8'h5A);
      repeat (17) drive_tick(1'b0, 1'b1, 8'h3C);
      drive_tick(1'b1, 1'b0, 8'hFF);
      drive_tick(1'b0, 1'b0, 8'h00);
      drive_tick(1'b1, 1'b0, 8'h81);

      // Bit periods of zero and one act as one tick per bit.
      write_bit_period(0);
      run_frames(100);
      write_bit_period(1);
      run_frames(100);
      write_bit_period(BIT_PERIOD_RESET);
      run_frames(300);

      // Random phases at small bit periods.
      random_start = ticks_sent;
      phase        = 0;
      while (ticks_sent - random_start < RANDOM_TICKS || phase < MIN_PHASES) begin
         write_bit_period(PERIOD_WIDTH'(($urandom_range(0, 9) < 7) ? $urandom_range(2, 12)
                                                                  : $urandom_range(13, 40)));
         steady = (phase % 4 == 3);
         if (phase == 1) begin
            // Sender pauses until every response is back.
            play_frame();
            settle();
         end
         if (phase == 2)
            sink_hold_request = 1'b1;
         run_frames(PHASE_TICKS);
         phase++;
      end
      steady = 1'b0;

      // Largest bit period: frames start but cannot finish within the run.
      write_bit_period('1);
      for (int i = 0; i < 150; i++)
         drive_tick((i < 8) || (i >= 12 && $urandom_range(0, 1) == 1),
                    ($urandom_range(0, 19) == 0), BYTE_WIDTH'($urandom));

      settle();
      if (sb.pending() != 0) begin
         $display("%0t: %0d responses never arrived", $time, sb.pending());
         sb.failures++;
      end
      if (sb.failures == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

endmodule

@@ sim.f @@
sv/uart_pkg.sv
sv/uart_tx.sv
sv/uart_rx.sv
sv/timer_uart_8n1_transceiver.sv
test/tb_top.sv
